>>> sv/frcv_pkg.sv
// ----------------------------------------------------------------------------
// frcv_pkg: shared constants and CRC helpers for the fault record validator
// Record length, CRC-32 (reflected) constants and the one-word update matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package frcv_pkg;

  localparam int unsigned RECORD_WORDS = 11;
  localparam int unsigned POS_W        = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_WORDS - 1);
  localparam logic [31:0] RECORD_LEN_WORD = 32'(RECORD_WORDS);

  localparam logic [31:0] CRC_START = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;  // 35 bits of fields, padded to bytes

  typedef logic [31:0] crc_cols_t [32];

  // Column i is the 32-step CRC image of a lone bit i; built at elaboration.
  function automatic crc_cols_t build_cols();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int k = 0; k < 32; k++) begin
        c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = build_cols();

  // One word through the CRC: linear, so an XOR of matrix columns.
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
    logic [31:0] c;
    logic [31:0] r;
    c = crc ^ word;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (c[i]) begin
        r = r ^ CRC_COLS[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/fault_record_crc_validator_top.sv
// ----------------------------------------------------------------------------
// fault_record_crc_validator_top: fault record length and CRC checker
// Walks a fixed-size record word by word and reports one verdict per record.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle unless a result waits in the output
// register with m_axis_tready low, which holds s_axis_tready low; the
// word rate is set by the combinational CRC update (an XOR matrix over one
// 32-bit word) feeding the accumulator register. A word with tuser set starts
// a record; after the last word the block expects word 0 again. One output
// transaction follows each completed record, carrying the verdict, the length
// check, the CRC check and the CRC computed over all words but the last.
`default_nettype none

module fault_record_crc_validator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [frcv_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] data_word
  input  wire logic                            s_axis_tuser,  // [0] first_word
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] record_valid, [1] length_ok, [2] crc_ok, [34:3] computed_crc, [39:35] zero
  output logic [frcv_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

  logic [31:0]                crc_q, crc_d;
  logic [frcv_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       len_q, len_d;
  logic                       out_valid_q, out_valid_d;
  logic [34:0]                out_data_q, out_data_d;

  logic                       s_accept;
  logic [frcv_pkg::POS_W-1:0] pos_eff;
  logic [31:0]                crc_eff;
  logic                       is_last;
  logic                       crc_match;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // a first-word flag restarts the record before the word is used
  assign pos_eff   = s_axis_tuser ? '0 : pos_q;
  assign crc_eff   = s_axis_tuser ? frcv_pkg::CRC_START : crc_q;
  assign is_last   = (pos_eff >= frcv_pkg::LAST_POS);
  assign crc_match = (crc_eff == s_axis_tdata);

  always_comb begin
    crc_d       = crc_q;
    pos_d       = pos_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    if (s_accept) begin
      if (!is_last) begin
        if (pos_eff == '0) begin
          len_d = (s_axis_tdata == frcv_pkg::RECORD_LEN_WORD);
        end
        crc_d = frcv_pkg::crc_word(crc_eff, s_axis_tdata);
        pos_d = pos_eff + 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_data_d  = {crc_eff, crc_match, len_q, crc_match && len_q};
        crc_d       = frcv_pkg::CRC_START;
        pos_d       = '0;
        len_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= frcv_pkg::CRC_START;
      pos_q       <= '0;
      len_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_data_q};

  // checks

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= frcv_pkg::LAST_POS)
    else $error("word position beyond record end");

  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s_accept && is_last))
    else $error("result appeared without a final word");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && is_last |=> pos_q == '0 && crc_q == frcv_pkg::CRC_START && !len_q)
    else $error("record state not restarted after final word");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[0] == (out_data_q[1] && out_data_q[2]))
    else $error("verdict disagrees with its checks");

endmodule

`default_nettype wire

>>> tb/sv/tb_fault_record_crc_validator_top.sv
// ----------------------------------------------------------------------------
// tb_fault_record_crc_validator_top: stream testbench for the record validator
// Feeds fault records word by word (good ones, broken lengths and CRCs,
// restarts and loose words), predicts each verdict with a bit-serial CRC-32
// and checks every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fault_record_crc_validator_top;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
  } rec_word_t;

  typedef struct packed {
    logic        record_valid;
    logic        length_ok;
    logic        crc_ok;
    logic [31:0] computed_crc;
  } verdict_t;

  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned IDLE_PCT     = 26;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [frcv_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] data_word
  logic                           s_axis_tuser  = 1'b0;  // [0] first_word
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [0] record_valid, [1] length_ok, [2] crc_ok, [34:3] computed_crc
  logic [frcv_pkg::M_TDATA_W-1:0] m_axis_tdata;

  rec_word_t   words_left[$];
  verdict_t    verdicts_due[$];
  rec_word_t   next_word;
  verdict_t    seen;
  verdict_t    due;

  // predictor state
  logic [31:0] crc_acc;
  logic [3:0]  word_pos;
  logic        len_match;

  // generator's view of the position, to know when a record must be flagged
  logic [3:0]  gen_pos;
  int unsigned words_taken;
  int unsigned mismatches;
  logic        calm;

  fault_record_crc_validator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // no idling on either side over this stretch of the stream
  assign calm = (words_taken >= 500) && (words_taken < 800);

  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] c;
    c = acc ^ w;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ frcv_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic take_word(input logic [31:0] w, input logic f);
    verdict_t v;
    if (f) begin
      crc_acc  = frcv_pkg::CRC_START;
      word_pos = '0;
    end
    if (word_pos == '0) begin
      len_match = (w == frcv_pkg::RECORD_LEN_WORD);
    end
    if (word_pos < frcv_pkg::LAST_POS) begin
      crc_acc  = crc_step(crc_acc, w);
      word_pos = word_pos + 4'd1;
    end else begin
      v.crc_ok       = (crc_acc == w);
      v.length_ok    = len_match;
      v.record_valid = v.crc_ok && v.length_ok;
      v.computed_crc = crc_acc;
      verdicts_due.push_back(v);
      crc_acc   = frcv_pkg::CRC_START;
      word_pos  = '0;
      len_match = 1'b0;
    end
  endtask

  task automatic push_word(input logic [31:0] w, input logic f);
    rec_word_t r;
    r.word  = w;
    r.first = f;
    words_left.push_back(r);
    if (f) begin
      gen_pos = '0;
    end
    gen_pos = (gen_pos >= frcv_pkg::LAST_POS) ? 4'd0 : gen_pos + 4'd1;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // alt_fill: body words alternate between all zeros and all ones
  task automatic add_record(input bit f, input bit len_good, input bit crc_good,
                            input bit alt_fill);
    logic [31:0] w;
    logic [31:0] acc;
    bit          flag;
    flag = f || (gen_pos != '0);
    acc  = frcv_pkg::CRC_START;
    if (len_good) begin
      w = frcv_pkg::RECORD_LEN_WORD;
    end else begin
      case ($urandom_range(4))
        0:       w = 32'h0;
        1:       w = frcv_pkg::RECORD_LEN_WORD - 32'd1;
        2:       w = frcv_pkg::RECORD_LEN_WORD + 32'd1;
        3:       w = 32'hFFFF_FFFF;
        default: w = $urandom;
      endcase
      if (w == frcv_pkg::RECORD_LEN_WORD) w = w ^ 32'h1;
    end
    push_word(w, flag);
    acc = crc_step(acc, w);
    for (int i = 1; i < frcv_pkg::RECORD_WORDS - 1; i++) begin
      w = alt_fill ? ((i % 2) ? 32'hFFFF_FFFF : 32'h0) : pick_word();
      push_word(w, 1'b0);
      acc = crc_step(acc, w);
    end
    if (crc_good) begin
      w = acc;
    end else if ($urandom_range(1)) begin
      w = acc ^ (32'h1 << $urandom_range(31));
    end else begin
      w = ~acc;
    end
    push_word(w, 1'b0);
  endtask

  // driver: one transaction per handshake, random idle cycles between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_word(s_axis_tdata[31:0], s_axis_tuser);
        words_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if ((words_left.size() != 0) && (calm || ($urandom_range(99) >= IDLE_PCT))) begin
          next_word = words_left.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.word;
          s_axis_tuser  <= next_word.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, each verdict checked against the oldest due
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.record_valid = m_axis_tdata[0];
        seen.length_ok    = m_axis_tdata[1];
        seen.crc_ok       = m_axis_tdata[2];
        seen.computed_crc = m_axis_tdata[34:3];
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected verdict transaction: %h", m_axis_tdata);
          end
        end else begin
          due = verdicts_due.pop_front();
          if (seen != due) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("verdict mismatch: exp valid %b len %b crc %b crc_val %h",
                       due.record_valid, due.length_ok, due.crc_ok, due.computed_crc);
              $display("                  got valid %b len %b crc %b crc_val %h",
                       seen.record_valid, seen.length_ok, seen.crc_ok, seen.computed_crc);
            end
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    crc_acc     = frcv_pkg::CRC_START;
    word_pos    = '0;
    len_match   = 1'b0;
    gen_pos     = '0;
    words_taken = 0;
    mismatches  = 0;

    // directed: unflagged record straight after reset, extreme body words
    add_record(1'b0, 1'b1, 1'b1, 1'b1);
    // next record without a flag, bad length word
    add_record(1'b0, 1'b0, 1'b1, 1'b0);
    // partial record, dropped by the restart that opens the random part unless that part opens with loose words
    push_word(frcv_pkg::RECORD_LEN_WORD, 1'b1);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0, 1'b0);

    while (words_left.size() < RANDOM_WORDS + 25) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        add_record(1'($urandom_range(1)), 1'b1, 1'b1, 1'b0);
      end else if (kind < 75) begin
        add_record(1'($urandom_range(1)), 1'b1, 1'b0, 1'b0);
      end else if (kind < 85) begin
        add_record(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 1'b0);
      end else if (kind < 95) begin
        n = $urandom_range(frcv_pkg::RECORD_WORDS - 1, 1);
        push_word($urandom_range(1) ? frcv_pkg::RECORD_LEN_WORD : pick_word(), 1'b1);
        for (int i = 1; i < n; i++) begin
          push_word(pick_word(), 1'b0);
        end
      end else begin
        // loose words with random first flags
        n = $urandom_range(15, 1);
        for (int i = 0; i < n; i++) begin
          push_word(pick_word(), ($urandom_range(3) == 0));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((words_left.size() != 0) || s_axis_tvalid) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (frcv_pkg::RECORD_WORDS + 20) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
